>>> rtl/core/bfloat16_add_sub_mul_unit_macros.svh
// Assertion macros shared by the bfloat16 unit.
`ifndef BFLOAT16_ADD_SUB_MUL_UNIT_MACROS_SVH
`define BFLOAT16_ADD_SUB_MUL_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define BF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define BF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> rtl/core/bf16_pkg.sv
package bf16_pkg;
  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_SUB = 2'd1;
  localparam logic [1:0] MODE_MUL = 2'd2;
  // The unused code is decoded on its high bit and multiplies as well.
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam logic [15:0] QUIET_NAN = 16'h7FC0;
  localparam logic [15:0] EXP_FIELD = 16'h7F80;

  // Classified operation handed from the front part to the back part.
  typedef struct packed {
    logic        is_mul;
    logic [15:0] a;
    logic [15:0] b;
  } bf16_op_t;
endpackage

>>> rtl/core/bf16_front.sv
module bf16_front
  import bf16_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] mode,
  input  logic [15:0] operand_a,
  input  logic [15:0] operand_b,
  output logic       op_valid,
  input  logic       op_ready,
  output bf16_op_t   op
);
  logic     full;
  bf16_op_t hold;

  assign in_ready = !full || op_ready;
  assign op_valid = full;
  assign op = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
  end

  // Subtract becomes an add with the sign of b flipped; mode 3 acts as multiply.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold.is_mul <= mode[1];
      hold.a <= operand_a;
      hold.b <= (mode == MODE_SUB) ? {~operand_b[15], operand_b[14:0]} : operand_b;
    end
  end
endmodule

>>> rtl/core/bf16_queue.sv
module bf16_queue
  import bf16_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     wr_valid,
  output logic     wr_ready,
  input  bf16_op_t wr_data,
  output logic     rd_valid,
  input  logic     rd_ready,
  output bf16_op_t rd_data
);
  bf16_op_t  mem [2];
  logic      wp, rp;
  logic [1:0] cnt;
  logic wr_en, rd_en;

  assign wr_ready = (cnt != 2'd2);
  assign rd_valid = (cnt != 2'd0);
  assign rd_data = mem[rp];
  assign wr_en = wr_valid && wr_ready;
  assign rd_en = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wp] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr_en) wp <= ~wp;
      if (rd_en) rp <= ~rp;
      cnt <= cnt + 2'(wr_en) - 2'(rd_en);
    end
  end
endmodule

>>> rtl/core/bf16_back.sv
module bf16_back
  import bf16_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     op_valid,
  output logic     op_ready,
  input  bf16_op_t op,
  output logic     res_valid,
  input  logic     res_ready,
  output logic [15:0] res
);
  logic [7:0] ea, eb, ma, mb, msa, msb, mr;
  logic sa, sb, sr, ea0, eb0, nana, nanb, infa, infb;
  logic [8:0] sum;
  logic [7:0] dif, diff_ab, diff_ba;
  logic [15:0] prod;
  logic signed [10:0] er;
  logic [3:0] lz;
  logic [15:0] r;
  logic done;

  assign op_ready = !res_valid || res_ready;

  always_comb begin
    ea = op.a[14:7]; eb = op.b[14:7];
    sa = op.a[15]; sb = op.b[15];
    ea0 = (ea == 8'd0); eb0 = (eb == 8'd0);
    nana = (ea == 8'hFF) && (op.a[6:0] != 7'd0);
    nanb = (eb == 8'hFF) && (op.b[6:0] != 7'd0);
    infa = (ea == 8'hFF) && (op.a[6:0] == 7'd0);
    infb = (eb == 8'hFF) && (op.b[6:0] == 7'd0);
    ma = {1'b1, op.a[6:0]}; mb = {1'b1, op.b[6:0]};
    diff_ab = ea - eb; diff_ba = eb - ea;
    msa = ma; msb = mb;
    sum = '0; dif = '0; prod = '0; lz = '0;
    er = '0; sr = 1'b0; mr = '0; done = 1'b0; r = '0;
    if (op.is_mul) begin
      sr = sa ^ sb;
      prod = ma * mb;
      if (nana) begin r = op.a; done = 1'b1; end
      else if (nanb) begin r = op.b; done = 1'b1; end
      else if (infa || infb) begin
        r = (ea0 || eb0) ? QUIET_NAN : {sr, EXP_FIELD[14:0]}; done = 1'b1;
      end else if (ea0 || eb0) begin r = {sr, 15'd0}; done = 1'b1; end
      else begin
        er = 11'(ea) + 11'(eb) - 11'sd127;
        if (prod[15]) begin mr = prod[15:8]; er = er + 11'sd1; end
        else mr = prod[14:7];
      end
    end else begin
      if (ea0) begin r = op.b; done = 1'b1; end
      else if (eb0) begin r = op.a; done = 1'b1; end
      else if (nana) begin r = op.a; done = 1'b1; end
      else if (nanb) begin r = op.b; done = 1'b1; end
      else if (infa) begin r = (infb && sa != sb) ? QUIET_NAN : op.a; done = 1'b1; end
      else if (infb) begin r = op.b; done = 1'b1; end
      else if (ea > eb && diff_ab > 8'd8) begin r = op.a; done = 1'b1; end
      else if (eb > ea && diff_ba > 8'd8) begin r = op.b; done = 1'b1; end
      else begin
        if (ea > eb) begin msb = mb >> diff_ab[3:0]; er = 11'(ea); end
        else begin msa = ma >> diff_ba[3:0]; er = 11'(eb); end
        if (sa == sb) begin
          sr = sa;
          sum = 9'(msa) + 9'(msb);
          if (sum[8]) begin mr = sum[8:1]; er = er + 11'sd1; end
          else mr = sum[7:0];
        end else begin
          if (msa > msb) begin sr = sa; dif = msa - msb; end
          else begin sr = sb; dif = msb - msa; end
          if (dif == 8'd0) begin r = 16'd0; done = 1'b1; end
          else begin
            // Leading-zero count for renormalization.
            for (int i = 0; i < 8; i++) begin
              if (dif[i]) lz = 4'(7 - i);
            end
            mr = dif << lz;
            er = er - 11'(lz);
          end
        end
      end
    end
    if (!done) begin
      if (er > 11'sd254) r = {sr, EXP_FIELD[14:0]};
      else if (er < 11'sd1) r = {sr, 15'd0};
      else r = {sr, er[7:0], mr[6:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (op_ready) begin
      res_valid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (op_valid && op_ready) begin
      res <= r;
    end
  end
endmodule

>>> rtl/core/bfloat16_add_sub_mul_unit.sv
// Path: an input transfer passes through the front register, the two-entry
// queue and the result register before the result transfer.
// Throughput: one transfer per cycle; the front and result registers take a new
// item in the cycle their current one moves on; the queue absorbs two items and
// takes one only when not full, so only downstream backpressure slows the unit.
// Reset: synchronous, active high; clears all valid flags and queue pointers.
`include "bfloat16_add_sub_mul_unit_macros.svh"
module bfloat16_add_sub_mul_unit
  import bf16_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0: mode[1:0], operand_a[17:2], operand_b[33:18], zero fill.
  input  logic [39:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0: result_word[15:0].
  output logic [15:0] m_axis_tdata
);
  logic     f_valid, f_ready, q_valid, q_ready;
  bf16_op_t f_op, q_op;

  // The front part decodes the mode and folds subtract into the sign of b.
  bf16_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .mode(s_axis_tdata[1:0]), .operand_a(s_axis_tdata[17:2]),
    .operand_b(s_axis_tdata[33:18]),
    .op_valid(f_valid), .op_ready(f_ready), .op(f_op)
  );

  // A short queue lets front and back stall independently.
  bf16_queue u_queue (
    .clk, .rst,
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_op),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_op)
  );

  // The back part computes the bfloat16 result into an output register.
  bf16_back u_back (
    .clk, .rst,
    .op_valid(q_valid), .op_ready(q_ready), .op(q_op),
    .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(m_axis_tdata)
  );

  // A stalled result must keep its value until it is taken.
  `BF_ASSERT_NXT(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")
  // The back part only pulls from the queue when it can store a result.
  `BF_ASSERT_IMP(a_pull, clk, rst, q_valid && q_ready, !m_axis_tvalid || m_axis_tready, "queue drained into a full result register")
  // A full queue pushes back on the front part.
  `BF_ASSERT_IMP(a_full, clk, rst, !f_ready, q_valid, "queue reports full while empty")
endmodule

>>> tb/bfloat16_add_sub_mul_unit_checker.sv
`timescale 1ns / 100ps
module bfloat16_add_sub_mul_unit_checker
  import bf16_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);

  logic [15:0] expected_words[$];

  function automatic logic is_nan_word(logic [15:0] w);
    return w[14:7] == 8'hFF && w[6:0] != 7'd0;
  endfunction

  function automatic logic is_inf_word(logic [15:0] w);
    return w[14:7] == 8'hFF && w[6:0] == 7'd0;
  endfunction

  function automatic logic [15:0] pack_word(logic s, int e, logic [8:0] sig);
    if (e > 254) return {s, EXP_FIELD[14:0]};
    if (e < 1) return {s, 15'd0};
    return {s, e[7:0], sig[6:0]};
  endfunction

  function automatic logic [15:0] bf16_sum(logic [15:0] a, logic [15:0] b);
    int ea, eb, er;
    logic [8:0] ma, mb, mr;
    logic sr;
    ea = int'(a[14:7]);
    eb = int'(b[14:7]);
    if (ea == 0) return b;
    if (eb == 0) return a;
    if (is_nan_word(a)) return a;
    if (is_nan_word(b)) return b;
    if (is_inf_word(a)) begin
      if (is_inf_word(b) && a[15] != b[15]) return QUIET_NAN;
      return a;
    end
    if (is_inf_word(b)) return b;
    ma = {2'b01, a[6:0]};
    mb = {2'b01, b[6:0]};
    if (ea > eb) begin
      if (ea - eb > 8) return a;
      mb = mb >> (ea - eb);
      er = ea;
    end else if (eb > ea) begin
      if (eb - ea > 8) return b;
      ma = ma >> (eb - ea);
      er = eb;
    end else begin
      er = ea;
    end
    if (a[15] == b[15]) begin
      sr = a[15];
      mr = ma + mb;
      if (mr[8]) begin
        mr = mr >> 1;
        er++;
      end
    end else begin
      if (ma > mb) begin
        sr = a[15];
        mr = ma - mb;
      end else if (mb > ma) begin
        sr = b[15];
        mr = mb - ma;
      end else begin
        return 16'h0000;
      end
      while (!mr[7]) begin
        mr = mr << 1;
        er--;
      end
    end
    return pack_word(sr, er, mr);
  endfunction

  function automatic logic [15:0] bf16_product(logic [15:0] a, logic [15:0] b);
    logic sr;
    logic [15:0] prod;
    int er;
    sr = a[15] ^ b[15];
    if (is_nan_word(a)) return a;
    if (is_nan_word(b)) return b;
    if (is_inf_word(a) || is_inf_word(b)) begin
      if (a[14:7] == 0 || b[14:7] == 0) return QUIET_NAN;
      return {sr, EXP_FIELD[14:0]};
    end
    if (a[14:7] == 0 || b[14:7] == 0) return {sr, 15'd0};
    prod = {9'd1, a[6:0]} * {9'd1, b[6:0]};
    er = int'(a[14:7]) + int'(b[14:7]) - 127;
    if (prod[15]) return pack_word(sr, er + 1, {1'b0, prod[15:8]});
    return pack_word(sr, er, {1'b0, prod[14:7]});
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count++;
  endtask

  assign pending_count = expected_words.size();

  initial begin
    fail_count = 0;
    result_count = 0;
  end

  always @(posedge clk) begin
    logic [1:0] mode;
    logic [15:0] a, b, want;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        mode = s_axis_tdata[1:0];
        a = s_axis_tdata[17:2];
        b = s_axis_tdata[33:18];
        // The high mode bit selects multiply, so the unused code multiplies too.
        if (mode[1]) expected_words.push_back(bf16_product(a, b));
        else if (mode == MODE_SUB) expected_words.push_back(bf16_sum(a, b ^ 16'h8000));
        else expected_words.push_back(bf16_sum(a, b));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        result_count++;
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
        end else begin
          want = expected_words.pop_front();
          if (m_axis_tdata !== want)
            report_mismatch($sformatf("result_word %h, expected %h", m_axis_tdata, want));
        end
      end
    end
  end

endmodule

>>> tb/bfloat16_add_sub_mul_unit_test.sv
`timescale 1ns / 100ps
module bfloat16_add_sub_mul_unit_test;
  import bf16_pkg::*;

  localparam int RANDOM_ITEMS = 1030;
  localparam int STALL_LIMIT = 2000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;
  int          fail_count, pending_count, result_count;
  int          idle_cycles;
  int          sent_count;
  logic        busy_stretch;  // When set, neither side inserts idle cycles.

  // Operand words grouped by class; the random part draws mostly from
  // normal numbers so the arithmetic paths are reached, with special
  // encodings mixed in.
  localparam logic [15:0] DIRECTED_A[22] = '{
    16'h0000, 16'h8000, 16'h0001, 16'h7F80, 16'hFF80, 16'h7FC0, 16'h3F80, 16'h3F80,
    16'h3F80, 16'h4000, 16'h7F7F, 16'h0080, 16'h3F80, 16'h7F80, 16'hFFFF, 16'h3F80,
    16'h7F7F, 16'h0080, 16'h3FFF, 16'h3F81, 16'h4480, 16'h7F80};
  localparam logic [15:0] DIRECTED_B[22] = '{
    16'h3F80, 16'h4000, 16'hBF80, 16'hFF80, 16'h7F80, 16'h3F80, 16'h7FC1, 16'h3F80,
    16'hBF80, 16'h3A00, 16'h7F7F, 16'h0080, 16'h4A00, 16'h0000, 16'h0000, 16'hBF7F,
    16'h4000, 16'h3F00, 16'h3FFF, 16'hBF80, 16'h0180, 16'h0001};
  localparam logic [1:0] DIRECTED_MODE[22] = '{
    MODE_ADD, MODE_ADD, MODE_SUB, MODE_ADD, MODE_SUB, MODE_ADD, MODE_MUL, MODE_SUB,
    MODE_ADD, MODE_ADD, MODE_MUL, MODE_MUL, MODE_ADD, MODE_MUL, MODE_SPARE, MODE_ADD,
    MODE_MUL, MODE_MUL, MODE_MUL, MODE_ADD, MODE_SUB, MODE_SPARE};

  bfloat16_add_sub_mul_unit i_dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  bfloat16_add_sub_mul_unit_checker i_checker (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .fail_count(fail_count), .pending_count(pending_count),
    .result_count(result_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [15:0] random_operand();
    int pick;
    logic [7:0] e;
    pick = $urandom_range(0, 99);
    if (pick < 8) e = 8'h00;
    else if (pick < 16) e = 8'hFF;
    else if (pick < 24) e = $urandom_range(0, 1) ? 8'h01 : 8'hFE;
    else if (pick < 40) e = 8'($urandom);
    else e = 8'($urandom_range(112, 142));
    return {1'(($urandom)), e, 7'($urandom)};
  endfunction

  // Builds one input transfer; operand b often sits near a's exponent so
  // alignment, cancellation and the far-exponent case are all reached.
  function automatic logic [39:0] random_item();
    logic [15:0] a, b;
    logic [1:0] mode;
    a = random_operand();
    b = random_operand();
    if ($urandom_range(0, 3) == 0 && a[14:7] != 8'h00 && a[14:7] != 8'hFF)
      b[14:7] = 8'(int'(a[14:7]) + $urandom_range(0, 20) - 10);
    if ($urandom_range(0, 19) == 0) b[14:0] = a[14:0];
    mode = $urandom_range(0, 9) == 0 ? MODE_SPARE : 2'($urandom_range(0, 2));
    return {6'd0, b, a, mode};
  endfunction

  function automatic logic idle_now();
    return !busy_stretch && $urandom_range(0, 99) < 28;
  endfunction

  // Receiver: random stalls on the result side.
  always @(posedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= !idle_now();
  end

  // Watchdog: counts cycles in which no transfer takes place on either side.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Presents one item and waits for its transfer; valid drops only when a
  // random gap comes before the item.
  task automatic send_item(logic [39:0] item);
    if (idle_now()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
      while (idle_now()) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= item;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sent_count++;
  endtask

  initial begin
    idle_cycles = 0;
    sent_count = 0;
    busy_stretch = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed part: signed zeros, subnormals, infinities, NaNs, exact
    // cancellation, carry-out, far exponents, overflow and underflow.
    for (int i = 0; i < 22; i++) begin
      send_item({6'd0, DIRECTED_B[i], DIRECTED_A[i], DIRECTED_MODE[i]});
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      busy_stretch = (i >= 400 && i < 600);
      send_item(random_item());
    end
    s_axis_tvalid <= 1'b0;
    busy_stretch = 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("ran %0d operations (directed specials, then random add, subtract, multiply)",
      sent_count);
    $display("checked %0d results with random stalls on both sides", result_count);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> bfloat16_add_sub_mul_unit.f
+incdir+rtl/core
rtl/core/bf16_pkg.sv
rtl/core/bf16_front.sv
rtl/core/bf16_queue.sv
rtl/core/bf16_back.sv
rtl/core/bfloat16_add_sub_mul_unit.sv
tb/bfloat16_add_sub_mul_unit_checker.sv
tb/bfloat16_add_sub_mul_unit_test.sv
